[rtl/core/salc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, constants and codes for the set-associative tag cache.
// ----------------------------------------------------------------------------
package salc_pkg;
    localparam int Ways       = 4;
    localparam int Sets       = 64;
    localparam int TableLines = 65536;
    localparam int WayW       = $clog2(Ways);
    localparam int SetW       = $clog2(Sets);
    localparam int TabW       = $clog2(TableLines);
    localparam int LineW      = 16;
    localparam int LtagW      = LineW - SetW;
    localparam int TagsW      = 8;
    localparam int AgeW       = (WayW > 0) ? WayW : 1;

    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_PRELOAD = 2'd2;

    localparam logic [1:0] KIND_WB   = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_RESP = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [LineW-1:0] line_index;
        logic [TagsW-1:0] tags_in;
    } t_in;

    typedef struct packed {
        logic [1:0]       record_kind;
        logic [LineW-1:0] line_out;
        logic [TagsW-1:0] tags_out;
        logic             hit;
        logic             last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item
        logic lookup;   // read set rams (registered)
        logic decide;   // resolve hit/victim, update set state
        logic tab_wr;   // preload table write
        logic wb_wr;    // write back victim
        logic fill_rd;  // read table for fill
        logic install;  // install filled line
        logic emit_wb;
        logic emit_fill;
        logic emit_resp;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       hit;
        logic       victim_valid;
    } t_sts;
endpackage
`default_nettype wire

[rtl/core/salc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_datapath
// Set storage, age update, backing table and output record register.
// ----------------------------------------------------------------------------
module salc_datapath
    import salc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_item,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output t_out      o_rec
);
    localparam int Rows = Sets;

    logic [Ways-1:0]            r_valid [Rows];
    logic [Ways-1:0][AgeW-1:0]  r_age_mem [Rows];
    logic [Ways*LtagW-1:0]      r_ltag_mem [Rows];
    logic [Ways*TagsW-1:0]      r_bits_mem [Rows];
    logic [TagsW-1:0]           r_table [TableLines];

    t_in                        r_item;
    logic [Ways*LtagW-1:0]      r_ltag_rd;
    logic [Ways*TagsW-1:0]      r_bits_rd;
    logic [Ways-1:0][AgeW-1:0]  r_age_rd;
    logic [WayW-1:0]            r_pick;
    logic                       r_hit;
    logic                       r_vvalid;
    logic [LineW-1:0]           r_vline;
    logic [TagsW-1:0]           r_vbits;
    logic [TagsW-1:0]           r_final;
    logic [TagsW-1:0]           r_fill;
    t_out                       r_rec;

    logic [SetW-1:0]  w_set;
    logic [LtagW-1:0] w_ltag;
    logic [TabW-1:0]  w_vslot;
    logic [TabW-1:0]  w_slot;

    assign w_set   = r_item.line_index[SetW-1:0];
    assign w_ltag  = r_item.line_index[LineW-1:SetW];
    assign w_slot  = r_item.line_index[TabW-1:0];
    assign w_vslot = r_vline[TabW-1:0];

    // an untouched set has no valid way and reads its way numbers as ages
    logic [Ways-1:0][AgeW-1:0] w_age_init;
    logic [Ways-1:0][AgeW-1:0] w_age;
    always_comb begin
        for (int w = 0; w < Ways; w++) begin
            w_age_init[w] = AgeW'(w);
        end
    end
    assign w_age = (r_valid[w_set] == '0) ? w_age_init : r_age_rd;

    logic [WayW-1:0] n_pick;
    logic            n_hit;
    logic            n_vvalid;
    logic            inv_found;
    logic [AgeW-1:0] oldest;
    always_comb begin
        n_pick    = '0;
        n_hit     = 1'b0;
        inv_found = 1'b0;
        oldest    = '0;
        for (int w = Ways - 1; w >= 0; w--) begin
            if (r_valid[w_set][w] &&
                r_ltag_rd[w*LtagW +: LtagW] == w_ltag) begin
                n_hit  = 1'b1;
            end
        end
        if (!n_hit) begin
            for (int w = 0; w < Ways; w++) begin
                if (!inv_found) begin
                    if (!r_valid[w_set][w]) begin
                        n_pick    = WayW'(w);
                        inv_found = 1'b1;
                    end else if (w_age[w] >= oldest) begin
                        oldest = w_age[w];
                        n_pick = WayW'(w);
                    end
                end
            end
        end else begin
            for (int w = Ways - 1; w >= 0; w--) begin
                if (r_valid[w_set][w] &&
                    r_ltag_rd[w*LtagW +: LtagW] == w_ltag) begin
                    n_pick = WayW'(w);
                end
            end
        end
        n_vvalid = !n_hit && !inv_found;
    end

    logic [AgeW-1:0]           used_age;
    logic [Ways-1:0][AgeW-1:0] n_age;
    always_comb begin
        used_age = w_age[n_pick];
        n_age    = w_age;
        for (int w = 0; w < Ways; w++) begin
            if (w_age[w] < used_age) begin
                n_age[w] = w_age[w] + AgeW'(1);
            end
        end
        n_age[n_pick] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Rows; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            if (i_cmd.decide) begin
                if (n_hit && r_item.action == ACT_WRITE) begin
                    r_bits_mem[w_set][n_pick*TagsW +: TagsW] <= r_item.tags_in;
                end
            end
            if (i_cmd.install) begin
                r_valid[w_set][r_pick] <= 1'b1;
                r_ltag_mem[w_set][r_pick*LtagW +: LtagW] <= w_ltag;
                r_bits_mem[w_set][r_pick*TagsW +: TagsW] <=
                    (r_item.action == ACT_WRITE) ? r_item.tags_in : r_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.lookup) begin
            r_ltag_rd <= r_ltag_mem[w_set];
            r_bits_rd <= r_bits_mem[w_set];
            r_age_rd  <= r_age_mem[w_set];
        end
        if (i_cmd.decide) begin
            r_age_mem[w_set] <= n_age;
            r_pick   <= n_pick;
            r_hit    <= n_hit;
            r_vvalid <= n_vvalid;
            r_vline  <= {r_ltag_rd[n_pick*LtagW +: LtagW], w_set};
            r_vbits  <= r_bits_rd[n_pick*TagsW +: TagsW];
            r_final  <= (r_item.action == ACT_WRITE) ? r_item.tags_in
                                                     : r_bits_rd[n_pick*TagsW +: TagsW];
        end
        if (i_cmd.tab_wr) begin
            r_table[w_slot] <= r_item.tags_in;
        end else if (i_cmd.wb_wr) begin
            r_table[w_vslot] <= r_vbits;
        end
        if (i_cmd.fill_rd) begin
            r_fill <= r_table[w_slot];
        end
        if (i_cmd.install) begin
            r_final <= (r_item.action == ACT_WRITE) ? r_item.tags_in : r_fill;
        end
        if (i_cmd.emit_wb) begin
            r_rec <= '{KIND_WB, r_vline, r_vbits, 1'b0, 1'b0};
        end else if (i_cmd.emit_fill) begin
            r_rec <= '{KIND_FILL, r_item.line_index, r_fill, 1'b0, 1'b0};
        end else if (i_cmd.emit_resp) begin
            r_rec <= '{KIND_RESP, r_item.line_index, r_final, r_hit, 1'b1};
        end
    end

    assign o_sts = '{r_item.action, r_hit, r_vvalid};
    assign o_rec = r_rec;
endmodule
`default_nettype wire

[rtl/core/salc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer for preload, lookup, write-back, fill and record transfers.
// ----------------------------------------------------------------------------
module salc_ctrl
    import salc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOK   = 4'd1;
    localparam logic [3:0] S_DEC    = 4'd2;
    localparam logic [3:0] S_WB     = 4'd3;
    localparam logic [3:0] S_FILL   = 4'd4;
    localparam logic [3:0] S_EFILL  = 4'd5;
    localparam logic [3:0] S_INST   = 4'd6;
    localparam logic [3:0] S_RESP   = 4'd7;
    localparam logic [3:0] S_WAITWB = 4'd8;
    localparam logic [3:0] S_WAITF  = 4'd9;
    localparam logic [3:0] S_WAITR  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       free;

    assign free    = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.action == ACT_PRELOAD) begin
                    o_cmd.tab_wr = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.action == ACT_READ || i_sts.action == ACT_WRITE) begin
                    o_cmd.lookup = 1'b1;
                    n_state      = S_DEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_WB;
            end
            S_WB: begin
                if (i_sts.hit) begin
                    n_state = S_RESP;
                end else if (i_sts.victim_valid) begin
                    n_state = S_WAITWB;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_WAITWB: begin
                if (free) begin
                    o_cmd.emit_wb = 1'b1;
                    o_cmd.wb_wr   = 1'b1;
                    n_ovalid      = 1'b1;
                    n_state       = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_rd = 1'b1;
                n_state       = S_WAITF;
            end
            S_WAITF: begin
                if (free) begin
                    o_cmd.emit_fill = 1'b1;
                    o_cmd.install   = 1'b1;
                    n_ovalid        = 1'b1;
                    n_state         = S_EFILL;
                end
            end
            S_EFILL: n_state = S_RESP;
            S_INST:  n_state = S_RESP;
            S_RESP:  n_state = S_WAITR;
            S_WAITR: begin
                if (free) begin
                    o_cmd.emit_resp = 1'b1;
                    n_ovalid        = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule
`default_nettype wire

[rtl/core/set_assoc_lru_tag_cache.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_cache
// Four-way, 64-set LRU cache of 8-bit line tag words over a 64K-entry table.
//
// Input channel (i_valid/o_ready, i_item) takes read, write or preload items;
// ready is high only while the block is idle, one item at a time.
// Output channel (o_valid/i_ready, o_rec) transfers records: a write-back
// when a valid way is evicted, a fill on a miss, then the response with
// last set. A preload transfers nothing.
// The sequencer steps through set read, decision, table write-back, table
// read and install, one per state.
// One output register holds each record; a stalled receiver holds the
// sequencer in its wait state with the record unchanged.
// Reset clears the valid bits; a set with no valid way reads its way numbers
// as ages. Line tags, tag words and the table are undefined until written.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_cache
    import salc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_item,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_rec
);
    t_cmd cmd;
    t_sts sts;

    salc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    salc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rec   (o_rec)
    );
endmodule
`default_nettype wire

[verif/set_assoc_lru_tag_cache_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_cache_test
// Self-checking bench for the LRU tag cache: a directed table of preloads,
// hits, misses, evictions and ignored items, then random access streams over
// three hot sets and any set. A behavioral copy of the cache and table
// predicts every record, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_cache_test;
    import salc_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int         NumDir   = 22;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_item;
    logic o_valid;
    logic i_ready;
    t_out o_rec;

    set_assoc_lru_tag_cache u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rec  (o_rec)
    );

    logic             way_valid [Ways*Sets];
    logic [LtagW-1:0] way_ltag  [Ways*Sets];
    logic [TagsW-1:0] way_bits  [Ways*Sets];
    logic [AgeW-1:0]  way_age   [Ways*Sets];
    logic [TagsW-1:0] tag_table [TableLines];
    bit               tab_known [TableLines];

    t_out pending_recs[$];
    int   errors;
    int   n_items;
    int   n_recs;
    int   n_hits;
    int   n_evicts;
    int   send_idle;
    int   recv_idle;
    bit   recv_hold;
    bit   dir_mode;

    t_in  dir_items [NumDir];
    t_out dir_recs  [NumDir];
    bit   dir_typed [NumDir];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_out mk_rec(logic [1:0] kind, logic [LineW-1:0] line,
                                    logic [TagsW-1:0] tags, logic hit, logic last);
        t_out r;
        r.record_kind = kind;
        r.line_out    = line;
        r.tags_out    = tags;
        r.hit         = hit;
        r.last        = last;
        return r;
    endfunction

    task automatic predict_access(t_in it);
        int               set_no;
        int               base;
        int               pick;
        int               oldest;
        bit               found;
        bit               chosen;
        logic [LtagW-1:0] ltag;
        logic [LineW-1:0] vline;
        logic [AgeW-1:0]  used;
        found  = 0;
        chosen = 0;
        pick   = 0;
        oldest = 0;
        if (it.action == ACT_PRELOAD) begin
            tag_table[it.line_index] = it.tags_in;
            tab_known[it.line_index] = 1;
            return;
        end
        if (it.action == ACT_NONE) return;
        set_no = it.line_index % Sets;
        ltag   = LtagW'(it.line_index / Sets);
        base   = set_no * Ways;
        for (int w = 0; w < Ways; w++) begin
            if (!found && way_valid[base+w] && way_ltag[base+w] == ltag) begin
                pick  = w;
                found = 1;
            end
        end
        if (!found) begin
            for (int w = 0; w < Ways; w++) begin
                if (!chosen) begin
                    if (!way_valid[base+w]) begin
                        pick   = w;
                        chosen = 1;
                    end else if (way_age[base+w] >= oldest) begin
                        oldest = way_age[base+w];
                        pick   = w;
                    end
                end
            end
            if (!chosen) begin
                vline = {way_ltag[base+pick], set_no[SetW-1:0]};
                tag_table[vline] = way_bits[base+pick];
                tab_known[vline] = 1;
                pending_recs.push_back(mk_rec(KIND_WB, vline, way_bits[base+pick],
                                              1'b0, 1'b0));
                n_evicts++;
            end
            pending_recs.push_back(mk_rec(KIND_FILL, it.line_index,
                                          tag_table[it.line_index], 1'b0, 1'b0));
            way_valid[base+pick] = 1;
            way_ltag[base+pick]  = ltag;
            way_bits[base+pick]  = tag_table[it.line_index];
        end else begin
            n_hits++;
        end
        if (it.action == ACT_WRITE) way_bits[base+pick] = it.tags_in;
        used = way_age[base+pick];
        if (used != 0) begin
            for (int w = 0; w < Ways; w++)
                if (way_age[base+w] < used) way_age[base+w] = way_age[base+w] + 1'b1;
            way_age[base+pick] = '0;
        end
        pending_recs.push_back(mk_rec(KIND_RESP, it.line_index, way_bits[base+pick],
                                      found, 1'b1));
    endtask

    // a fill must read a known table entry: the line is cached or was stored
    function automatic bit is_safe(t_in it);
        int set_no;
        if (it.action != ACT_READ && it.action != ACT_WRITE) return 1;
        if (tab_known[it.line_index]) return 1;
        set_no = it.line_index % Sets;
        for (int w = 0; w < Ways; w++)
            if (way_valid[set_no*Ways+w] && way_ltag[set_no*Ways+w] == it.line_index / Sets)
                return 1;
        return 0;
    endfunction

    task automatic send_item(t_in it);
        while (($urandom_range(99) < send_idle)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_access(it);
        if (it.action != ACT_NONE) n_items++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_recs.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_recs++;
            if (pending_recs.size() == 0) begin
                $error("unexpected record kind=%0d line=%0h", o_rec.record_kind,
                       o_rec.line_out);
                errors++;
            end else begin
                t_out e;
                e = pending_recs.pop_front();
                if (o_rec.record_kind !== e.record_kind) begin
                    $error("record_kind exp %0d got %0d", e.record_kind, o_rec.record_kind);
                    errors++;
                end
                if (o_rec.line_out !== e.line_out) begin
                    $error("line_out exp %0h got %0h", e.line_out, o_rec.line_out);
                    errors++;
                end
                if (o_rec.tags_out !== e.tags_out) begin
                    $error("tags_out exp %0h got %0h", e.tags_out, o_rec.tags_out);
                    errors++;
                end
                if (o_rec.hit !== e.hit) begin
                    $error("hit exp %0b got %0b", e.hit, o_rec.hit);
                    errors++;
                end
                if (o_rec.last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, o_rec.last);
                    errors++;
                end
            end
        end
    end

    function automatic t_in mk_in(logic [1:0] act, logic [LineW-1:0] line,
                                  logic [TagsW-1:0] tags);
        t_in it;
        it.action     = act;
        it.line_index = line;
        it.tags_in    = tags;
        return it;
    endfunction

    task automatic set_row(int i, t_in it, bit typed, t_out r);
        dir_items[i] = it;
        dir_typed[i] = typed;
        dir_recs[i]  = r;
    endtask

    task automatic run_random(int count);
        t_in         it;
        int          hot;
        logic [15:0] hi;
        for (int k = 0; k < count; k++) begin
            hot = $urandom_range(3);
            hi  = 16'($urandom_range(7));
            if ($urandom_range(99) < 4) hi = 16'hFFFF >> 6 - $urandom_range(1);
            it = mk_in(2'($urandom_range(99) < 20 ? ACT_PRELOAD : $urandom_range(1)),
                       {hi[9:0], (hot == 3) ? 6'($urandom_range(63)) : 6'(hot * 21)},
                       8'($urandom));
            if ($urandom_range(99) < 2) it.action = ACT_NONE;
            if (!is_safe(it)) it.action = ACT_PRELOAD;
            send_item(it);
        end
    endtask

    initial begin
        t_out z;
        z         = '0;
        errors    = 0;
        n_items   = 0;
        n_recs    = 0;
        n_hits    = 0;
        n_evicts  = 0;
        recv_hold = 0;
        send_idle = 0;
        recv_idle = 0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_item    = '0;
        for (int i = 0; i < Ways*Sets; i++) begin
            way_valid[i] = 0;
            way_age[i]   = AgeW'(i % Ways);
        end
        for (int i = 0; i < TableLines; i++) tab_known[i] = 0;

        // directed table: preload, extremes, fills, evictions, ignored code
        set_row(0,  mk_in(ACT_PRELOAD, 16'h0000, 8'hA5), 0, z);
        set_row(1,  mk_in(ACT_PRELOAD, 16'hFFFF, 8'hFF), 0, z);
        set_row(2,  mk_in(ACT_READ,    16'h0000, 8'h00), 1,
                mk_rec(KIND_FILL, 16'h0000, 8'hA5, 1'b0, 1'b0));
        set_row(3,  mk_in(ACT_READ,    16'h0000, 8'h00), 1,
                mk_rec(KIND_RESP, 16'h0000, 8'hA5, 1'b1, 1'b1));
        set_row(4,  mk_in(ACT_WRITE,   16'hFFFF, 8'h00), 0, z);
        set_row(5,  mk_in(ACT_READ,    16'hFFFF, 8'h00), 0, z);
        set_row(6,  mk_in(ACT_NONE,    16'h1234, 8'h5A), 0, z);
        set_row(7,  mk_in(ACT_PRELOAD, 16'h0040, 8'h01), 0, z);
        set_row(8,  mk_in(ACT_PRELOAD, 16'h0080, 8'h02), 0, z);
        set_row(9,  mk_in(ACT_PRELOAD, 16'h00C0, 8'h04), 0, z);
        set_row(10, mk_in(ACT_PRELOAD, 16'h0100, 8'h08), 0, z);
        set_row(11, mk_in(ACT_WRITE,   16'h0040, 8'h55), 0, z);
        set_row(12, mk_in(ACT_READ,    16'h0080, 8'h00), 0, z);
        set_row(13, mk_in(ACT_READ,    16'h00C0, 8'h00), 0, z);
        set_row(14, mk_in(ACT_READ,    16'h0100, 8'h00), 0, z);
        set_row(15, mk_in(ACT_READ,    16'h0040, 8'h00), 0, z);
        set_row(16, mk_in(ACT_PRELOAD, 16'h0080, 8'hEE), 0, z);
        set_row(17, mk_in(ACT_READ,    16'h0080, 8'h00), 0, z);
        set_row(18, mk_in(ACT_READ,    16'h0000, 8'h00), 0, z);
        set_row(19, mk_in(ACT_WRITE,   16'h0100, 8'hFF), 0, z);
        set_row(20, mk_in(ACT_READ,    16'h0000, 8'h00), 0, z);
        set_row(21, mk_in(ACT_READ,    16'hFFC0, 8'h00), 0, z);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NumDir; i++) begin
            if (!is_safe(dir_items[i])) dir_items[i].action = ACT_PRELOAD;
            if (dir_typed[i]) begin
                int before_n;
                before_n = pending_recs.size();
                send_item(dir_items[i]);
                if (pending_recs[pending_recs.size()-1] !== dir_recs[i]
                        && pending_recs[before_n] !== dir_recs[i]) begin
                    $error("typed row %0d: expected record %p", i, dir_recs[i]);
                    errors++;
                end
            end else begin
                send_item(dir_items[i]);
            end
        end
        drain();

        send_idle = 28;
        recv_idle = 74;
        run_random(150);
        drain();

        send_idle = 74;
        recv_idle = 28;
        run_random(150);

        // hold the output for a long stretch while items keep coming
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge i_clk);
                recv_hold = 0;
            end
            run_random(20);
        join
        drain();

        run_random(140);
        drain();

        $display("Run covered %0d accesses and preloads, %0d records, %0d hits, %0d evictions.",
                 n_items, n_recs, n_hits, n_evicts);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[set_assoc_lru_tag_cache.f]
rtl/core/salc_pkg.sv
rtl/core/salc_datapath.sv
rtl/core/salc_ctrl.sv
rtl/core/set_assoc_lru_tag_cache.sv
verif/set_assoc_lru_tag_cache_test.sv
